// ----- rtl/cwa_pkg.sv -----
package cwa_pkg;

  localparam int W = 64;
  localparam int DIV_STAGES = W;

  localparam logic [W-1:0] TOP_BIT = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_NEG = 4'd5,
    OP_INV = 4'd6,
    OP_AND = 4'd7,
    OP_OR  = 4'd8,
    OP_XOR = 4'd9,
    OP_CMP = 4'd10
  } op_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OVF  = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;

  typedef struct packed {
    logic         ok;
    logic [W-1:0] bits;
    logic         big;
  } pack_t;

  typedef struct packed {
    logic [W-1:0] bits;
    logic         big;
    logic [1:0]   err;
    logic         less;
    logic         eq;
  } res_t;

  // Signed-magnitude value to result encoding; ok is low when out of range.
  function automatic pack_t pack_sm(input logic neg, input logic [W-1:0] mag);
    pack_t p;
    logic  n;
    n = neg & (mag != '0);
    p.ok = !n || (mag <= TOP_BIT);
    p.bits = n ? (~mag + 1'b1) : mag;
    p.big = !n & mag[W-1];
    return p;
  endfunction

endpackage

// ----- rtl/checked_wide_integer_alu.sv -----
// Overflow-checked ALU over integers from -2^63 to 2^64-1.
// Input channel in_*: opcode and two operands, each a 64-bit pattern plus a
// big flag (set: unsigned value of at least 2^63). Output channel out_*: one
// result item per input item, in order, with a result pattern, big flag,
// error code and the compare flags. Both channels use valid/ready.
// Throughput is one item per cycle for every opcode while the output is not
// stalled. The depth is set by the divider: 64 restoring stages of one
// quotient bit each, behind an operand decode register and ahead of the
// output register. Multiply uses four 32x32 partial products over two stages.
// All other operations ride a delay line beside the divider so that items
// leave in order.
// The whole pipeline advances when the output register is empty or taken;
// in_ready is that same condition, so a stall holds every item in place.
// Synchronous reset clears all valid bits; data registers are not reset.
module checked_wide_integer_alu (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            in_op,
  input  logic [cwa_pkg::W-1:0] in_a_bits,
  input  logic                  in_a_big,
  input  logic [cwa_pkg::W-1:0] in_b_bits,
  input  logic                  in_b_big,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [cwa_pkg::W-1:0] out_res_bits,
  output logic                  out_res_big,
  output logic [1:0]            out_error,
  output logic                  out_is_less,
  output logic                  out_is_equal
);
  import cwa_pkg::*;

  localparam int H = W / 2;
  localparam int DLY = DIV_STAGES - 3;

  typedef struct packed {
    logic [3:0]   op;
    logic         a_neg;
    logic [W-1:0] a_mag;
    logic         b_neg;
    logic [W-1:0] b_mag;
    logic [W-1:0] a_bits;
    logic         a_big;
    logic [W-1:0] b_bits;
    logic         b_big;
  } p0_t;

  typedef struct packed {
    logic [3:0]   op;
    logic         neg;
    logic [W-1:0] mag;
    logic         carry;
    logic [W-1:0] lbits;
    logic         lbig;
    logic         less;
    logic         eq;
    logic         bzero;
  } s2_t;

  typedef struct packed {
    s2_t          s;
    logic [W-1:0] pll;
    logic [W-1:0] plh;
    logic [W-1:0] phl;
    logic [W-1:0] phh;
  } s1_t;

  typedef struct packed {
    logic [3:0] op;
    logic       neg;
    logic       bzero;
    res_t       res;
  } side_t;

  logic en;
  logic p0_v_r, s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic [DLY-1:0] dly_v_r;
  p0_t   p0_r, p0_nxt;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  side_t s3_r, s3_nxt;
  side_t dly_r [DLY];
  res_t  out_r, out_nxt;
  logic [W-1:0] div_q, div_rem;

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  // Operand decode into sign and magnitude.
  always_comb begin
    p0_nxt.op = in_op;
    p0_nxt.a_neg = !in_a_big & in_a_bits[W-1];
    p0_nxt.a_mag = p0_nxt.a_neg ? (~in_a_bits + 1'b1) : in_a_bits;
    p0_nxt.b_neg = !in_b_big & in_b_bits[W-1];
    p0_nxt.b_mag = p0_nxt.b_neg ? (~in_b_bits + 1'b1) : in_b_bits;
    p0_nxt.a_bits = in_a_bits;
    p0_nxt.a_big = in_a_big;
    p0_nxt.b_bits = in_b_bits;
    p0_nxt.b_big = in_b_big;
  end

  // Add/sub/neg, bitwise, compare and the multiplier partial products.
  always_comb begin
    logic       bn;
    logic [W:0] sum, dab;
    bn = p0_r.b_neg ^ (p0_r.op == OP_SUB);
    sum = {1'b0, p0_r.a_mag} + {1'b0, p0_r.b_mag};
    dab = {1'b0, p0_r.a_mag} - {1'b0, p0_r.b_mag};
    s1_nxt = '0;
    s1_nxt.s.op = p0_r.op;
    s1_nxt.s.bzero = (p0_r.b_mag == '0);
    s1_nxt.s.neg = p0_r.a_neg ^ p0_r.b_neg;
    if (p0_r.op == OP_NEG) begin
      s1_nxt.s.neg = !p0_r.a_neg;
      s1_nxt.s.mag = p0_r.a_mag;
    end else if (p0_r.op == OP_ADD || p0_r.op == OP_SUB) begin
      if (p0_r.a_neg == bn) begin
        s1_nxt.s.neg = p0_r.a_neg;
        s1_nxt.s.mag = sum[W-1:0];
        s1_nxt.s.carry = sum[W];
      end else if (!dab[W]) begin
        s1_nxt.s.neg = p0_r.a_neg;
        s1_nxt.s.mag = dab[W-1:0];
      end else begin
        s1_nxt.s.neg = bn;
        s1_nxt.s.mag = p0_r.b_mag - p0_r.a_mag;
      end
    end
    case (p0_r.op)
      OP_INV:  s1_nxt.s.lbits = ~p0_r.a_bits;
      OP_AND:  s1_nxt.s.lbits = p0_r.a_bits & p0_r.b_bits;
      OP_OR:   s1_nxt.s.lbits = p0_r.a_bits | p0_r.b_bits;
      OP_XOR:  s1_nxt.s.lbits = p0_r.a_bits ^ p0_r.b_bits;
      default: s1_nxt.s.lbits = '0;
    endcase
    s1_nxt.s.lbig = (p0_r.op inside {OP_AND, OP_OR, OP_XOR}) & s1_nxt.s.lbits[W-1]
                    & (p0_r.a_big | p0_r.b_big);
    if (p0_r.a_neg != p0_r.b_neg) begin
      s1_nxt.s.less = p0_r.a_neg;
    end else if (p0_r.a_neg) begin
      s1_nxt.s.less = p0_r.a_mag > p0_r.b_mag;
    end else begin
      s1_nxt.s.less = p0_r.a_mag < p0_r.b_mag;
    end
    s1_nxt.s.eq = (p0_r.a_mag == p0_r.b_mag)
                  && ((p0_r.a_neg == p0_r.b_neg) || (p0_r.a_mag == '0));
    s1_nxt.pll = p0_r.a_mag[H-1:0] * p0_r.b_mag[H-1:0];
    s1_nxt.plh = p0_r.a_mag[H-1:0] * p0_r.b_mag[W-1:H];
    s1_nxt.phl = p0_r.a_mag[W-1:H] * p0_r.b_mag[H-1:0];
    s1_nxt.phh = p0_r.a_mag[W-1:H] * p0_r.b_mag[W-1:H];
  end

  // Combine the partial products; any high half bit means overflow.
  always_comb begin
    logic [H+1:0] mid;
    logic [W-1:0] hi;
    mid = {2'b00, s1_r.pll[W-1:H]} + {2'b00, s1_r.plh[H-1:0]}
          + {2'b00, s1_r.phl[H-1:0]};
    hi = s1_r.phh + {{H{1'b0}}, s1_r.plh[W-1:H]} + {{H{1'b0}}, s1_r.phl[W-1:H]}
         + {{(W-2){1'b0}}, mid[H+1:H]};
    s2_nxt = s1_r.s;
    if (s1_r.s.op == OP_MUL) begin
      s2_nxt.mag = {mid[H-1:0], s1_r.pll[H-1:0]};
      s2_nxt.carry = (hi != '0);
    end
  end

  always_comb begin
    pack_t p;
    p = pack_sm(s2_r.neg, s2_r.mag);
    s3_nxt = '0;
    s3_nxt.op = s2_r.op;
    s3_nxt.neg = s2_r.neg;
    s3_nxt.bzero = s2_r.bzero;
    case (s2_r.op)
      OP_ADD, OP_SUB, OP_MUL, OP_NEG: begin
        if (s2_r.carry || !p.ok) begin
          s3_nxt.res.err = ERR_OVF;
        end else begin
          s3_nxt.res.bits = p.bits;
          s3_nxt.res.big = p.big;
        end
      end
      OP_INV, OP_AND, OP_OR, OP_XOR: begin
        s3_nxt.res.bits = s2_r.lbits;
        s3_nxt.res.big = s2_r.lbig;
      end
      OP_CMP: begin
        s3_nxt.res.less = s2_r.less;
        s3_nxt.res.eq = s2_r.eq;
      end
      default: begin
      end
    endcase
  end

  cwa_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (p0_r.a_mag),
    .divisor  (p0_r.b_mag),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // Divide and modulo results join the side line at the last stage.
  always_comb begin
    side_t sd;
    pack_t p;
    sd = dly_r[DLY-1];
    p = pack_sm(sd.neg, (sd.op == OP_DIV) ? div_q : div_rem);
    out_nxt = sd.res;
    if (sd.op == OP_DIV || sd.op == OP_MOD) begin
      out_nxt = '0;
      if (sd.bzero) begin
        out_nxt.err = ERR_DIV0;
      end else if (!p.ok) begin
        out_nxt.err = ERR_OVF;
      end else begin
        out_nxt.bits = p.bits;
        out_nxt.big = p.big;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= p0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      dly_r[0] <= s3_r;
      for (int i = 1; i < DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      dly_v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p0_v_r <= in_valid;
      s1_v_r <= p0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      dly_v_r <= {dly_v_r[DLY-2:0], s3_v_r};
      out_valid_r <= dly_v_r[DLY-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res_bits = out_r.bits;
  assign out_res_big = out_r.big;
  assign out_error = out_r.err;
  assign out_is_less = out_r.less;
  assign out_is_equal = out_r.eq;

  a_err_clears_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error != ERR_NONE) |-> (out_res_bits == '0) && !out_res_big)
    else $error("error result carries a nonzero value");

  a_cmp_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_less && out_is_equal))
    else $error("compare reports both less and equal");

  a_cmp_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_is_less || out_is_equal) |-> (out_res_bits == '0)
      && (out_error == ERR_NONE) && !out_res_big)
    else $error("compare result carries value or error");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(dly_v_r))
    else $error("pipeline moved while output stalled");

endmodule

// ----- rtl/cwa_div.sv -----
module cwa_div (
  input  logic                  clk,
  input  logic                  en,
  input  logic [cwa_pkg::W-1:0] dividend,
  input  logic [cwa_pkg::W-1:0] divisor,
  output logic [cwa_pkg::W-1:0] quot,
  output logic [cwa_pkg::W-1:0] rem
);
  import cwa_pkg::*;

  // One restoring step per stage; the quotient bits shift in as the
  // dividend bits shift out of the same register.
  logic [W-1:0] rem_r [DIV_STAGES];
  logic [W-1:0] q_r   [DIV_STAGES];
  logic [W-1:0] d_r   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
    logic [W-1:0] rem_in, q_in, d_in, rem_nxt;
    logic [W:0]   trial, diff;
    logic         ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = dividend;
      assign d_in   = divisor;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign d_in   = d_r[i-1];
    end

    always_comb begin
      trial = {rem_in, q_in[W-1]};
      diff = trial - {1'b0, d_in};
      ge = !diff[W];
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        q_r[i]   <= {q_in[W-2:0], ge};
        d_r[i]   <= d_in;
      end
    end
  end

  assign quot = q_r[DIV_STAGES-1];
  assign rem  = rem_r[DIV_STAGES-1];

endmodule

// ----- sim/checked_wide_integer_alu_tb.sv -----
module checked_wide_integer_alu_tb;
  import cwa_pkg::*;

  class alu_scoreboard;
    res_t expected_q[$];
    int   n_checked;
    int   n_fail;
    int   n_ovf;
    int   n_div0;

    function new();
      n_checked = 0;
      n_fail = 0;
      n_ovf = 0;
      n_div0 = 0;
    endfunction

    // Exact result of one operation, worked in sign-magnitude form.
    function res_t evaluate(logic [3:0] op, logic [W-1:0] ab, logic abig,
                            logic [W-1:0] bb, logic bbig);
      logic         an, bn, rn, carry, arith;
      logic [W-1:0] am, bm, rm;
      logic [W:0]   sum;
      logic [2*W-1:0] prod;
      res_t         r;
      r = '0;
      an = !abig && ab[W-1];
      bn = !bbig && bb[W-1];
      am = an ? -ab : ab;
      bm = bn ? -bb : bb;
      rn = 1'b0;
      rm = '0;
      carry = 1'b0;
      arith = 1'b0;
      case (op)
        OP_ADD, OP_SUB: begin
          if (op == OP_SUB) bn = !bn;
          if (an == bn) begin
            sum = {1'b0, am} + {1'b0, bm};
            rn = an;
            rm = sum[W-1:0];
            carry = sum[W];
          end else if (am >= bm) begin
            rn = an;
            rm = am - bm;
          end else begin
            rn = bn;
            rm = bm - am;
          end
          arith = 1'b1;
        end
        OP_MUL: begin
          prod = {{W{1'b0}}, am} * {{W{1'b0}}, bm};
          carry = prod[2*W-1:W] != '0;
          rn = an ^ bn;
          rm = prod[W-1:0];
          arith = 1'b1;
        end
        OP_DIV, OP_MOD: begin
          if (bm == '0) begin
            r.err = ERR_DIV0;
          end else begin
            rn = an ^ bn;
            rm = (op == OP_DIV) ? am / bm : am % bm;
            arith = 1'b1;
          end
        end
        OP_NEG: begin
          rn = !an;
          rm = am;
          arith = 1'b1;
        end
        OP_INV: r.bits = ~ab;
        OP_AND, OP_OR, OP_XOR: begin
          r.bits = (op == OP_AND) ? (ab & bb) : (op == OP_OR) ? (ab | bb) : (ab ^ bb);
          r.big = r.bits[W-1] && (abig || bbig);
        end
        OP_CMP: begin
          if (an != bn) r.less = an;
          else if (an) r.less = am > bm;
          else r.less = am < bm;
          r.eq = (am == bm) && (an == bn || am == '0);
        end
        default: ;
      endcase
      if (arith) begin
        if (rm == '0) rn = 1'b0;
        if (carry || (rn && rm > TOP_BIT)) begin
          r.err = ERR_OVF;
        end else begin
          r.bits = rn ? -rm : rm;
          r.big = !rn && rm[W-1];
        end
      end
      return r;
    endfunction

    function void note_input(logic [3:0] op, logic [W-1:0] ab, logic abig,
                             logic [W-1:0] bb, logic bbig);
      expected_q.push_back(evaluate(op, ab, abig, bb, bbig));
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected: bits=%h", got.bits);
        n_fail++;
        return;
      end
      exp_r = expected_q.pop_front();
      n_checked++;
      if (exp_r.err == ERR_OVF) n_ovf++;
      if (exp_r.err == ERR_DIV0) n_div0++;
      if (got.bits !== exp_r.bits) begin
        $error("res_bits: expected %h, got %h", exp_r.bits, got.bits);
        n_fail++;
      end
      if (got.big !== exp_r.big) begin
        $error("res_big: expected %b, got %b", exp_r.big, got.big);
        n_fail++;
      end
      if (got.err !== exp_r.err) begin
        $error("error: expected %0d, got %0d", exp_r.err, got.err);
        n_fail++;
      end
      if (got.less !== exp_r.less) begin
        $error("is_less: expected %b, got %b", exp_r.less, got.less);
        n_fail++;
      end
      if (got.eq !== exp_r.eq) begin
        $error("is_equal: expected %b, got %b", exp_r.eq, got.eq);
        n_fail++;
      end
    endfunction
  endclass

  localparam logic [W-1:0] ALL_ONES = '1;
  localparam logic [W-1:0] MAX_POS = ~TOP_BIT;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [3:0]   in_op;
  logic [W-1:0] in_a_bits;
  logic         in_a_big;
  logic [W-1:0] in_b_bits;
  logic         in_b_big;
  logic         out_valid;
  logic         out_ready;
  logic [W-1:0] out_res_bits;
  logic         out_res_big;
  logic [1:0]   out_error;
  logic         out_is_less;
  logic         out_is_equal;

  alu_scoreboard sb = new();
  bit            long_hold_req = 1'b0;
  int            n_sent = 0;

  checked_wide_integer_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_a_bits(in_a_bits), .in_a_big(in_a_big),
    .in_b_bits(in_b_bits), .in_b_big(in_b_big),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_bits(out_res_bits), .out_res_big(out_res_big), .out_error(out_error),
    .out_is_less(out_is_less), .out_is_equal(out_is_equal)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_res_bits, out_res_big, out_error, out_is_less, out_is_equal});
  end

  // Receiver: switches among random stall patterns; on request it holds off for a
  // long stretch so the pipeline fills and backs up into the input.
  initial begin
    int mode;
    int cyc;
    out_ready = 1'b0;
    mode = 0;
    cyc = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(3);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(3) != 0);
          2: out_ready <= ($urandom_range(3) == 0);
          default: out_ready <= (cyc % 5 < 3);
        endcase
        cyc++;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [3:0] op, logic [W-1:0] ab, logic abig,
                           logic [W-1:0] bb, logic bbig);
    in_valid <= 1'b1;
    in_op <= op;
    in_a_bits <= ab;
    in_a_big <= abig;
    in_b_bits <= bb;
    in_b_big <= bbig;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, ab, abig, bb, bbig);
    n_sent++;
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Operand pattern and big flag, weighted toward the range limits.
  function automatic logic [W:0] pick_operand();
    logic [W-1:0] v;
    logic         big;
    case ($urandom_range(9))
      0: v = '0;
      1: v = 64'd1;
      2: v = ALL_ONES;
      3: v = TOP_BIT;
      4: v = MAX_POS;
      5: v = 64'($urandom_range(40));
      6: v = -64'($urandom_range(40));
      7: v = {32'd0, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    big = v[W-1] ? ($urandom_range(1) == 1) : ($urandom_range(15) == 0);
    return {big, v};
  endfunction

  task automatic send_random();
    logic [W:0] a, b;
    logic [3:0] op;
    a = pick_operand();
    b = pick_operand();
    if ($urandom_range(31) == 0) op = 4'($urandom_range(15, int'(OP_CMP) + 1));
    else op = 4'($urandom_range(int'(OP_CMP)));
    send_item(op, a[W-1:0], a[W], b[W-1:0], b[W]);
  endtask

  initial begin
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ADD;
    in_a_bits = '0;
    in_a_big = 1'b0;
    in_b_bits = '0;
    in_b_big = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_ADD, ALL_ONES, 1'b1, 64'd1, 1'b0);
    send_item(OP_ADD, MAX_POS, 1'b0, 64'd1, 1'b0);
    send_item(OP_SUB, TOP_BIT, 1'b0, 64'd1, 1'b0);
    send_item(OP_SUB, TOP_BIT, 1'b1, ALL_ONES, 1'b0);
    send_item(OP_MUL, 64'h1_0000_0000, 1'b0, 64'h1_0000_0000, 1'b0);
    send_item(OP_MUL, TOP_BIT, 1'b0, 64'd1, 1'b0);
    send_item(OP_MUL, ALL_ONES, 1'b0, TOP_BIT, 1'b0);
    send_item(OP_DIV, ALL_ONES, 1'b1, 64'd0, 1'b0);
    send_item(OP_MOD, 64'd7, 1'b0, 64'd0, 1'b1);
    send_item(OP_DIV, -64'd7, 1'b0, 64'd2, 1'b0);
    send_item(OP_MOD, -64'd7, 1'b0, -64'd3, 1'b0);
    send_item(OP_NEG, TOP_BIT, 1'b0, '0, 1'b0);
    send_item(OP_NEG, ALL_ONES, 1'b1, '0, 1'b0);
    send_item(OP_NEG, TOP_BIT, 1'b1, '0, 1'b0);
    send_item(OP_INV, 64'h0123_4567_89ab_cdef, 1'b0, ALL_ONES, 1'b1);
    send_item(OP_AND, ALL_ONES, 1'b1, TOP_BIT, 1'b0);
    send_item(OP_OR, 64'd5, 1'b0, TOP_BIT, 1'b0);
    send_item(OP_XOR, ALL_ONES, 1'b0, MAX_POS, 1'b1);
    send_item(OP_CMP, ALL_ONES, 1'b0, ALL_ONES, 1'b1);
    send_item(OP_CMP, TOP_BIT, 1'b1, TOP_BIT, 1'b1);
    send_item(OP_CMP, 64'd5, 1'b1, 64'd5, 1'b0);
    send_item(OP_ADD, 64'd5, 1'b1, -64'd9, 1'b0);
    send_item(4'($urandom_range(15, int'(OP_CMP) + 1)), ALL_ONES, 1'b1, ALL_ONES, 1'b1);
    wait_drained();

    while (n_sent < 1220) begin
      burst = $urandom_range(1, 24);
      repeat (burst) send_random();
      if (n_sent > 400 && n_sent < 430) long_hold_req = 1'b1;
      if (n_sent > 800 && n_sent < 830) wait_drained();
      else if ($urandom_range(2) == 0) idle_cycles($urandom_range(1, 8));
    end
    wait_drained();
    repeat (80) @(posedge clk);

    $display("Checked %0d result items over all opcodes,", sb.n_checked);
    $display("incl. %0d overflows and %0d divides by zero.", sb.n_ovf, sb.n_div0);
    if (sb.n_fail == 0 && sb.expected_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
